@@ design/sha1_message_digest_macros.svh @@
// ---------------------------------------------------------------------------
// sha1 message digest assertion macros
// clocked checks for the port-level checker
// ---------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_MACROS_SVH

// implication in the same cycle, masked during reset
`define SHA1_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// implication into the next cycle, masked during reset
`define SHA1_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// implication into the next cycle, also checked through reset
`define SHA1_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/sha1_pkg.sv @@
// ---------------------------------------------------------------------------
// sha1 package
// shared types and constants of the sha1 message digest
// ---------------------------------------------------------------------------
package sha1_pkg;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = QPtrW + 1;

    localparam int BlockBits   = 512;
    localparam int DigestBits  = 160;

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [2:0] LastIdx = 3'd4;

    localparam logic [DigestBits-1:0] HInit = {
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } t_item;

    typedef struct packed {
        logic  vld;
        t_item item;
    } t_qout;

    typedef struct packed {
        logic                 full;
        logic                 fin;
        logic [BlockBits-1:0] data;
    } t_blk;

endpackage

@@ design/sha1_front.sv @@
// ---------------------------------------------------------------------------
// sha1 front end
// takes input requests, drops empty non-final ones and queues the rest
// ---------------------------------------------------------------------------
module sha1_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  logic [7:0]     i_data_byte,
    input  logic           i_byte_valid,
    input  logic           i_last_byte,
    output logic           o_full,
    input  logic           i_take,
    output sha1_pkg::t_qout o_q
);
    import sha1_pkg::*;

    t_item              r_mem [QDepth];
    logic [QPtrW-1:0]   r_wr;
    logic [QPtrW-1:0]   r_rd;
    logic [QCntW-1:0]   r_cnt;
    logic [QCntW-1:0]   n_cnt;
    logic               wr_en;
    logic               rd_en;

    assign o_full = (r_cnt == QCntW'(QDepth));
    assign wr_en  = i_push && !o_full && (i_byte_valid || i_last_byte);
    assign rd_en  = i_take && (r_cnt != '0);

    always_comb begin
        n_cnt = r_cnt;
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!wr_en && rd_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= '{data: i_data_byte, valid: i_byte_valid, last: i_last_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (wr_en) begin
                r_wr <= r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    assign o_q.vld  = (r_cnt != '0);
    assign o_q.item = r_mem[r_rd];

endmodule

@@ design/sha1_load.sv @@
// ---------------------------------------------------------------------------
// sha1 block loader
// packs bytes into a 64-byte block, appends padding and the bit length
// ---------------------------------------------------------------------------
module sha1_load (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sha1_pkg::t_qout i_q,
    output logic            o_take,
    input  logic            i_blk_take,
    output sha1_pkg::t_blk  o_blk
);
    import sha1_pkg::*;

    localparam logic [1:0] LdData = 2'd0;
    localparam logic [1:0] LdPad  = 2'd1;
    localparam logic [1:0] LdZero = 2'd2;
    localparam logic [1:0] LdLen  = 2'd3;

    logic [1:0]           r_st;
    logic [1:0]           n_st;
    logic [BlockBits-1:0] r_buf;
    logic [5:0]           r_fill;
    logic                 r_full;
    logic                 r_fin;
    logic [63:0]          r_bits;
    logic [63:0]          n_bits;
    logic [2:0]           r_lcnt;
    logic [2:0]           n_lcnt;
    logic                 ins;
    logic [7:0]           ins_byte;
    logic                 len_end;

    always_comb begin
        n_st     = r_st;
        n_bits   = r_bits;
        n_lcnt   = r_lcnt;
        ins      = 1'b0;
        ins_byte = '0;
        len_end  = 1'b0;
        o_take   = 1'b0;
        case (r_st)
            LdData: begin
                if (i_q.vld && !r_full) begin
                    o_take = 1'b1;
                    if (i_q.item.valid) begin
                        ins      = 1'b1;
                        ins_byte = i_q.item.data;
                        n_bits   = r_bits + 64'd8;
                    end
                    if (i_q.item.last) begin
                        n_st = LdPad;
                    end
                end
            end
            LdPad: begin
                if (!r_full) begin
                    ins      = 1'b1;
                    ins_byte = PadByte;
                    n_st     = LdZero;
                end
            end
            LdZero: begin
                if (!r_full) begin
                    if (r_fill == 6'd56) begin
                        n_st   = LdLen;
                        n_lcnt = '0;
                    end else begin
                        ins = 1'b1;
                    end
                end
            end
            LdLen: begin
                if (!r_full) begin
                    ins      = 1'b1;
                    ins_byte = r_bits[63:56];
                    n_bits   = {r_bits[55:0], 8'h00};
                    n_lcnt   = r_lcnt + 1'b1;
                    if (r_lcnt == 3'd7) begin
                        len_end = 1'b1;
                        n_st    = LdData;
                    end
                end
            end
            default: begin
                n_st = LdData;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ins) begin
            r_buf <= {r_buf[BlockBits-9:0], ins_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= LdData;
            r_fill <= '0;
            r_full <= 1'b0;
            r_fin  <= 1'b0;
            r_bits <= '0;
            r_lcnt <= '0;
        end else begin
            r_st   <= n_st;
            r_bits <= n_bits;
            r_lcnt <= n_lcnt;
            if (ins) begin
                r_fill <= r_fill + 1'b1;
                if (r_fill == 6'd63) begin
                    r_full <= 1'b1;
                    r_fin  <= len_end;
                end
            end else if (i_blk_take) begin
                r_full <= 1'b0;
            end
        end
    end

    assign o_blk.full = r_full;
    assign o_blk.fin  = r_fin;
    assign o_blk.data = r_buf;

endmodule

@@ design/sha1_core.sv @@
// ---------------------------------------------------------------------------
// sha1 compression core
// 80 rounds per block, chaining update and digest output register
// ---------------------------------------------------------------------------
module sha1_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sha1_pkg::t_blk i_blk,
    output logic           o_blk_take,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [31:0]    o_digest_word,
    output logic [2:0]     o_word_index,
    output logic           o_last_word
);
    import sha1_pkg::*;

    localparam logic [1:0] CrIdle = 2'd0;
    localparam logic [1:0] CrRun  = 2'd1;
    localparam logic [1:0] CrFin  = 2'd2;

    logic [1:0]            r_st;
    logic [6:0]            r_rnd;
    logic                  r_fin;
    logic [DigestBits-1:0] r_h;
    logic [DigestBits-1:0] r_v;
    logic [BlockBits-1:0]  r_w;
    logic [DigestBits-1:0] r_dig;
    logic                  r_busy;
    logic [2:0]            r_idx;

    logic [31:0] va, vb, vc, vd, ve;
    logic [31:0] w0, w2, w8, w13, wx;
    logic [31:0] f, k, temp;
    logic [DigestBits-1:0] sum;

    assign {va, vb, vc, vd, ve} = r_v;
    assign w0  = r_w[511:480];
    assign w2  = r_w[447:416];
    assign w8  = r_w[255:224];
    assign w13 = r_w[95:64];
    assign wx  = w13 ^ w8 ^ w2 ^ w0;

    always_comb begin
        if (r_rnd < 7'd20) begin
            f = (vb & vc) | (~vb & vd);
            k = K0;
        end else if (r_rnd < 7'd40) begin
            f = vb ^ vc ^ vd;
            k = K1;
        end else if (r_rnd < 7'd60) begin
            f = (vb & vc) | (vd & (vb | vc));
            k = K2;
        end else begin
            f = vb ^ vc ^ vd;
            k = K3;
        end
        temp = {va[26:0], va[31:27]} + f + ve + k + w0;
    end

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            sum[32*i +: 32] = r_h[32*i +: 32] + r_v[32*i +: 32];
        end
    end

    assign o_blk_take = (r_st == CrIdle) && i_blk.full;

    always_ff @(posedge i_clk) begin
        case (r_st)
            CrIdle: begin
                if (o_blk_take) begin
                    r_v <= r_h;
                    r_w <= i_blk.data;
                end
            end
            CrRun: begin
                r_v <= {temp, va, {vb[1:0], vb[31:2]}, vc, vd};
                r_w <= {r_w[BlockBits-33:0], wx[30:0], wx[31]};
            end
            default: begin
            end
        endcase
        if ((r_st == CrFin) && r_fin && !r_busy) begin
            r_dig <= sum;
        end else if (i_pop && r_busy) begin
            r_dig <= {r_dig[DigestBits-33:0], 32'h0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= CrIdle;
            r_rnd  <= '0;
            r_fin  <= 1'b0;
            r_h    <= HInit;
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            case (r_st)
                CrIdle: begin
                    if (o_blk_take) begin
                        r_fin <= i_blk.fin;
                        r_rnd <= '0;
                        r_st  <= CrRun;
                    end
                end
                CrRun: begin
                    r_rnd <= r_rnd + 1'b1;
                    if (r_rnd == 7'd79) begin
                        r_st <= CrFin;
                    end
                end
                CrFin: begin
                    if (!r_fin) begin
                        r_h  <= sum;
                        r_st <= CrIdle;
                    end else if (!r_busy) begin
                        r_h  <= HInit;
                        r_st <= CrIdle;
                    end
                end
                default: begin
                    r_st <= CrIdle;
                end
            endcase
            if ((r_st == CrFin) && r_fin && !r_busy) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (i_pop && r_busy) begin
                r_idx <= r_idx + 1'b1;
                if (r_idx == LastIdx) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_empty       = !r_busy;
    assign o_digest_word = r_dig[DigestBits-1 -: 32];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == LastIdx);

endmodule

@@ design/sha1_message_digest.sv @@
// ---------------------------------------------------------------------------
// sha1 message digest
// byte-serial sha-1 hash with a queued front end and a round core
// ---------------------------------------------------------------------------
// input: one request per message byte (i_data_byte, i_byte_valid,
//   i_last_byte), taken when push is high and full is low. a request with
//   i_byte_valid low and i_last_byte low is dropped; i_last_byte ends the
//   message, with i_byte_valid low for an empty message.
// output: five requests per message, digest word 0 first, taken when pop is
//   high and empty is low; o_last_word marks word 4.
// rate: the loader packs one byte per cycle into a 64-byte block while the
//   queue holds bytes and the block register is free, and the core compresses
//   the previous block (start, 80 rounds, chaining add); a long message thus
//   runs at the pace set by the round unit.
// finish: after the last byte, the loader appends padding and length, then
//   the core compresses one or two blocks before the digest shows up.
// stall: the digest stays on the ports until popped; loading and rounds of
//   the next message go on, and only a further digest waits for the port.
// reset: synchronous, clears the queue, the fill and bit counts, the output
//   and loads the initial chaining words.
// ---------------------------------------------------------------------------
module sha1_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_last_byte,
    input  logic        push,
    output logic        full,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word,
    output logic        empty,
    input  logic        pop
);
    import sha1_pkg::*;

    t_qout q;
    t_blk  blk;
    logic  q_take;
    logic  blk_take;

    sha1_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_data_byte  (i_data_byte),
        .i_byte_valid (i_byte_valid),
        .i_last_byte  (i_last_byte),
        .o_full       (full),
        .i_take       (q_take),
        .o_q          (q)
    );

    sha1_load u_load (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q        (q),
        .o_take     (q_take),
        .i_blk_take (blk_take),
        .o_blk      (blk)
    );

    sha1_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_blk         (blk),
        .o_blk_take    (blk_take),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule

@@ design/sha1_checker.sv @@
// ---------------------------------------------------------------------------
// sha1 port checker
// port-level checks on the digest output channel
// ---------------------------------------------------------------------------
`include "sha1_message_digest_macros.svh"

module sha1_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word,
    input logic        empty,
    input logic        pop
);

    `SHA1_ASSERT_RST(a_rst_empty, !i_rst_n, empty, "output not empty after reset")

    `SHA1_ASSERT_NOW(a_last_flag, !empty,
        o_last_word == (o_word_index == 3'd4), "last word flag wrong")

    `SHA1_ASSERT_NEXT(a_word_seq, pop && !empty && !o_last_word,
        !empty && (o_word_index == $past(o_word_index) + 3'd1),
        "digest words out of sequence")

    `SHA1_ASSERT_NEXT(a_hold, !empty && !pop,
        !empty && $stable(o_digest_word) && $stable(o_word_index),
        "stalled digest word changed")

endmodule

bind sha1_message_digest sha1_checker u_chk (.*);

@@ bench/tb_sha1_message_digest.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha1 message digest testbench
// feeds byte messages of random length through the push side, including
// empty messages, idle requests and lengths around the padding limits. the
// bench hashes every message itself and checks each digest word popped from
// the block. sender gaps and receiver stalls vary by phase, and one long
// receiver hold-off backs the block up into its input.
// ---------------------------------------------------------------------------
module tb_sha1_message_digest;
    import sha1_pkg::*;

    localparam int HoldCycles  = 600;
    localparam int HoldAfter   = 5;
    localparam int ItemCount   = 110;
    localparam int DrainCycles = 300;
    localparam int CycleLimit  = 400000;

    localparam logic [31:0] RoundK0 = 32'h5a827999;
    localparam logic [31:0] RoundK1 = 32'h6ed9eba1;
    localparam logic [31:0] RoundK2 = 32'h8f1bbcdc;
    localparam logic [31:0] RoundK3 = 32'hca62c1d6;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic [7:0]  i_data_byte  = 8'h00;
    logic        i_byte_valid = 1'b0;
    logic        i_last_byte  = 1'b0;
    logic        push         = 1'b0;
    logic        pop          = 1'b0;
    logic        full;
    logic        empty;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    t_item        byte_q[$];
    t_digest_word digest_q[$];

    logic [31:0] chain_h[5];
    logic [31:0] sched_w[16];
    logic [5:0]  blk_fill;
    logic [63:0] msg_bits;

    logic [1:0]   idle_phase = 2'd0;
    bit           send_gap;
    bit           held       = 1'b0;
    int           hold_left  = 0;
    int           err_cnt    = 0;
    int           sent_cnt   = 0;
    int           got_cnt    = 0;
    int           cycle_cnt  = 0;
    t_digest_word exp_w;

    sha1_message_digest dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_data_byte  (i_data_byte),
        .i_byte_valid (i_byte_valid),
        .i_last_byte  (i_last_byte),
        .push         (push),
        .full         (full),
        .o_digest_word(o_digest_word),
        .o_word_index (o_word_index),
        .o_last_word  (o_last_word),
        .empty        (empty),
        .pop          (pop)
    );

    function automatic logic [31:0] rotl(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void restart_chain();
        chain_h[0] = 32'h67452301;
        chain_h[1] = 32'hefcdab89;
        chain_h[2] = 32'h98badcfe;
        chain_h[3] = 32'h10325476;
        chain_h[4] = 32'hc3d2e1f0;
        blk_fill   = 6'd0;
        msg_bits   = 64'd0;
    endfunction

    function automatic void sha1_compress();
        logic [31:0] a, b, c, d, e, f, w;
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < 80; r++) begin
            if (r >= 16) begin
                w = sched_w[(r + 13) % 16] ^ sched_w[(r + 8) % 16]
                  ^ sched_w[(r + 2) % 16] ^ sched_w[r % 16];
                sched_w[r % 16] = rotl(w, 1);
            end
            if (r < 20)
                f = ((b & c) | (~b & d)) + RoundK0;
            else if (r < 40)
                f = (b ^ c ^ d) + RoundK1;
            else if (r < 60)
                f = ((b & c) | (d & (b | c))) + RoundK2;
            else
                f = (b ^ c ^ d) + RoundK3;
            f = f + rotl(a, 5) + e + sched_w[r % 16];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = f;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    function automatic void put_byte(logic [5:0] pos, logic [7:0] b);
        if (pos[1:0] == 2'd0)
            sched_w[pos[5:2]] = {b, 24'h000000};
        else
            sched_w[pos[5:2]] |= {24'h000000, b} << (8 * (3 - int'(pos[1:0])));
    endfunction

    function automatic void predict_digest(t_item it);
        t_digest_word rec;
        if (it.valid) begin
            put_byte(blk_fill, it.data);
            msg_bits += 64'd8;
            blk_fill = blk_fill + 6'd1;
            if (blk_fill == 6'd0)
                sha1_compress();
        end
        if (it.last) begin
            put_byte(blk_fill, 8'h80);
            for (int i = int'(blk_fill[5:2]) + 1; i < 16; i++)
                sched_w[i] = 32'h0;
            if (blk_fill >= 6'd56) begin
                sha1_compress();
                for (int i = 0; i < 16; i++)
                    sched_w[i] = 32'h0;
            end
            sched_w[14] = msg_bits[63:32];
            sched_w[15] = msg_bits[31:0];
            sha1_compress();
            for (int k = 0; k < 5; k++) begin
                rec.word  = chain_h[k];
                rec.index = 3'(k);
                rec.last  = (k == 4);
                digest_q.push_back(rec);
            end
            restart_chain();
        end
    endfunction

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        int  n_items;
        int  len;
        int  sel;
        bit  tail_empty;
        n_items = 0;
        restart_chain();
        for (int i = 0; i < 16; i++)
            sched_w[i] = 32'h0;

        // empty message, single extreme bytes, "abc", idle requests, alternating bits
        byte_q.push_back(t_item'{8'h00, 1'b0, 1'b1});
        byte_q.push_back(t_item'{8'h00, 1'b1, 1'b1});
        byte_q.push_back(t_item'{8'hff, 1'b1, 1'b1});
        byte_q.push_back(t_item'{8'h61, 1'b1, 1'b0});
        byte_q.push_back(t_item'{8'h62, 1'b1, 1'b0});
        byte_q.push_back(t_item'{8'h63, 1'b1, 1'b1});
        byte_q.push_back(t_item'{8'hff, 1'b0, 1'b0});
        byte_q.push_back(t_item'{8'h5a, 1'b1, 1'b0});
        byte_q.push_back(t_item'{8'h00, 1'b0, 1'b0});
        byte_q.push_back(t_item'{8'hff, 1'b0, 1'b1});
        byte_q.push_back(t_item'{8'h55, 1'b1, 1'b0});
        byte_q.push_back(t_item'{8'haa, 1'b1, 1'b1});
        n_items = byte_q.size();

        // random messages, some around the padding and block limits
        while (n_items < ItemCount) begin
            sel = $urandom_range(9);
            if (sel < 6)
                len = $urandom_range(12);
            else if (sel < 8)
                len = $urandom_range(68, 52);
            else if (sel == 8)
                len = $urandom_range(130, 110);
            else
                len = 0;
            if (len > ItemCount - n_items)
                len = ItemCount - n_items;
            tail_empty = (len == 0) || ($urandom_range(3) == 0);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(11) == 0) begin
                    byte_q.push_back(t_item'{8'($urandom), 1'b0, 1'b0});
                    n_items++;
                end
                byte_q.push_back(t_item'{8'($urandom), 1'b1, !tail_empty && i == len - 1});
            end
            if (tail_empty)
                byte_q.push_back(t_item'{8'($urandom), 1'b0, 1'b1});
            n_items += len + int'(tail_empty);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_q.size() != 0 || push)
            @(posedge i_clk);
        while (digest_q.size() != 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_digest(byte_q.pop_front());
                sent_cnt++;
                idle_phase <= 2'((sent_cnt / 40) % 4);
            end
            if (!push || !full) begin
                case (idle_phase)
                    2'd1:    send_gap = $urandom_range(99) < 80;
                    2'd3:    send_gap = $urandom_range(99) < 10;
                    default: send_gap = 1'b0;
                endcase
                if (byte_q.size() != 0 && !send_gap) begin
                    push         <= 1'b1;
                    i_data_byte  <= byte_q[0].data;
                    i_byte_valid <= byte_q[0].valid;
                    i_last_byte  <= byte_q[0].last;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // long hold-off so the block backs up into its input
    always @(posedge i_clk) begin
        if (!held && got_cnt >= HoldAfter) begin
            held      <= 1'b1;
            hold_left <= HoldCycles;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // digest monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got_cnt++;
                if (digest_q.size() == 0) begin
                    $error("unexpected digest word %h index %0d", o_digest_word, o_word_index);
                    err_cnt++;
                end else begin
                    exp_w = digest_q.pop_front();
                    if (o_digest_word !== exp_w.word) begin
                        $error("digest_word expected %h got %h", exp_w.word, o_digest_word);
                        err_cnt++;
                    end
                    if (o_word_index !== exp_w.index) begin
                        $error("word_index expected %0d got %0d", exp_w.index, o_word_index);
                        err_cnt++;
                    end
                    if (o_last_word !== exp_w.last) begin
                        $error("last_word expected %b got %b", exp_w.last, o_last_word);
                        err_cnt++;
                    end
                end
            end
            if (hold_left > 0) begin
                pop <= 1'b0;
            end else begin
                case (idle_phase)
                    2'd2:    pop <= $urandom_range(99) >= 80;
                    2'd3:    pop <= $urandom_range(99) >= 10;
                    default: pop <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
